/* rtl/core/ebcx_pkg.sv */
// ----------------------------------------------------------------------------
// ebcx_pkg
// Shared types and constants of the 8-bit processor execute unit.
// ----------------------------------------------------------------------------
package ebcx_pkg;

  localparam logic [15:0] STACK_BASE = 16'd256;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ASL = 6'd3,
    OP_BCC = 6'd4,  OP_BCS = 6'd5,  OP_BEQ = 6'd6,  OP_BIT = 6'd7,
    OP_BMI = 6'd8,  OP_BNE = 6'd9,  OP_BPL = 6'd10, OP_BVC = 6'd11,
    OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
    OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
    OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
    OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
    OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
    OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SEC = 6'd43,
    OP_SED = 6'd44, OP_SEI = 6'd45, OP_STA = 6'd46, OP_STX = 6'd47,
    OP_STY = 6'd48, OP_TAX = 6'd49, OP_TAY = 6'd50, OP_TSX = 6'd51,
    OP_TXA = 6'd52, OP_TXS = 6'd53, OP_TYA = 6'd54
  } op_e;

  // decoded instruction handed from front to back
  typedef struct packed {
    op_e         op;
    logic        acc_mode;
    logic [15:0] addr;
    logic [7:0]  mem;
    logic [15:0] pc;
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [7:0]  s3;
  } instr_t;

  typedef struct packed {
    logic        wv;
    logic [15:0] wa;
    logic [7:0]  wd;
    logic        last;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  fl;
    logic [15:0] pc;
  } result_t;

endpackage

/* rtl/core/ebcx_front.sv */
// ----------------------------------------------------------------------------
// ebcx_front
// Accepts input beats, classifies the operation and queues decoded items.
// ----------------------------------------------------------------------------
module ebcx_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [5:0]           op_i,
  input  logic [15:0]          addr_i,
  input  logic [7:0]           mem_i,
  input  logic [15:0]          pc_i,
  input  logic [7:0]           s1_i,
  input  logic [7:0]           s2_i,
  input  logic [7:0]           s3_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output ebcx_pkg::instr_t     q_data_o
);
  import ebcx_pkg::*;

  instr_t    mem_q [QUEUE_DEPTH];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  instr_t    item;
  logic      push, pop;

  always_comb begin
    item.addr     = addr_i;
    item.acc_mode = (addr_i == 16'd0);
    item.mem      = mem_i;
    item.pc       = pc_i;
    item.s1       = s1_i;
    item.s2       = s2_i;
    item.s3       = s3_i;
    // unknown codes execute as NOP
    if (op_i > 6'd54) item.op = OP_NOP;
    else item.op = op_e'(op_i);
  end

  assign in_ready_o = (cnt_q != 2'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end

endmodule

/* rtl/core/ebcx_back.sv */
// ----------------------------------------------------------------------------
// ebcx_back
// Executes queued instructions against the register file and drives
// result beats through an output register.
// ----------------------------------------------------------------------------
module ebcx_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  ebcx_pkg::instr_t   q_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ebcx_pkg::result_t  out_data_o
);
  import ebcx_pkg::*;

  logic [7:0] a_q, x_q, y_q, sp_q, fl_q;
  logic [7:0] a_d, x_d, y_d, sp_d, fl_d;
  logic       ov_q;
  result_t    res_q;
  logic       jsr2_q;   // second push of a call pending
  logic [7:0] ret_lo_q;
  logic [15:0] jsr_wa_q;

  logic       slot_free, take, fire;
  logic       wv;
  logic [15:0] wa, pc_n, ret;
  logic [7:0] wd, cur, r, m, opnd, cmp_reg;
  logic [8:0] sum;
  instr_t     i;

  assign i         = q_data_i;
  assign m         = i.mem;
  assign slot_free = !ov_q || out_ready_i;
  assign q_ready_o = slot_free && !jsr2_q;
  assign take      = q_valid_i && q_ready_o;
  assign fire      = slot_free && jsr2_q;

  always_comb begin
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; fl_d = fl_q;
    wv = 1'b0; wa = 16'd0; wd = 8'd0; pc_n = i.pc; r = 8'd0;
    cur  = i.acc_mode ? a_q : m;
    opnd = (i.op == OP_SBC) ? ~m : m;
    sum  = {1'b0, a_q} + {1'b0, opnd} + {8'd0, fl_q[0]};
    cmp_reg = (i.op == OP_CPX) ? x_q : ((i.op == OP_CPY) ? y_q : a_q);
    ret = i.pc - 16'd1;
    case (i.op)
      OP_ADC, OP_SBC: begin
        a_d = sum[7:0]; fl_d[0] = sum[8];
        fl_d[6] = (~(a_q[7] ^ opnd[7])) & (a_q[7] ^ sum[7]);
        r = sum[7:0];
      end
      OP_AND: begin a_d = a_q & m; r = a_d; end
      OP_EOR: begin a_d = a_q ^ m; r = a_d; end
      OP_ORA: begin a_d = a_q | m; r = a_d; end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        case (i.op)
          OP_ASL:  r = {cur[6:0], 1'b0};
          OP_LSR:  r = {1'b0, cur[7:1]};
          OP_ROL:  r = {cur[6:0], fl_q[0]};
          default: r = {fl_q[0], cur[7:1]};
        endcase
        fl_d[0] = (i.op == OP_ASL || i.op == OP_ROL) ? cur[7] : cur[0];
        if (i.acc_mode) a_d = r;
        else begin wv = 1'b1; wa = i.addr; wd = r; end
      end
      OP_BCC: if (!fl_q[0]) pc_n = i.addr;
      OP_BCS: if (fl_q[0]) pc_n = i.addr;
      OP_BEQ: if (fl_q[1]) pc_n = i.addr;
      OP_BNE: if (!fl_q[1]) pc_n = i.addr;
      OP_BMI: if (fl_q[7]) pc_n = i.addr;
      OP_BPL: if (!fl_q[7]) pc_n = i.addr;
      OP_BVC: if (!fl_q[6]) pc_n = i.addr;
      OP_BVS: if (fl_q[6]) pc_n = i.addr;
      OP_BIT: begin fl_d[7] = m[7]; fl_d[6] = m[6]; fl_d[1] = (a_q & m) == 8'd0; end
      OP_CLC: fl_d[0] = 1'b0;
      OP_CLD: fl_d[3] = 1'b0;
      OP_CLI: fl_d[2] = 1'b0;
      OP_CLV: fl_d[6] = 1'b0;
      OP_SEC: fl_d[0] = 1'b1;
      OP_SED: fl_d[3] = 1'b1;
      OP_SEI: fl_d[2] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin fl_d[0] = cmp_reg >= m; r = cmp_reg - m; end
      OP_DEC, OP_INC: begin
        r = (i.op == OP_DEC) ? m - 8'd1 : m + 8'd1;
        wv = 1'b1; wa = i.addr; wd = r;
      end
      OP_DEX: begin x_d = x_q - 8'd1; r = x_d; end
      OP_DEY: begin y_d = y_q - 8'd1; r = y_d; end
      OP_INX: begin x_d = x_q + 8'd1; r = x_d; end
      OP_INY: begin y_d = y_q + 8'd1; r = y_d; end
      OP_JMP: pc_n = i.addr;
      OP_JSR: begin
        pc_n = i.addr; sp_d = sp_q - 8'd2;
        wv = 1'b1; wa = STACK_BASE + {8'd0, sp_q}; wd = ret[15:8];
      end
      OP_LDA: begin a_d = m; r = m; end
      OP_LDX: begin x_d = m; r = m; end
      OP_LDY: begin y_d = m; r = m; end
      OP_PHA, OP_PHP: begin
        wv = 1'b1; wa = STACK_BASE + {8'd0, sp_q};
        wd = (i.op == OP_PHA) ? a_q : (fl_q & 8'hDF);
        sp_d = sp_q - 8'd1;
      end
      OP_PLA: begin a_d = i.s1; sp_d = sp_q + 8'd1; r = i.s1; end
      OP_PLP: begin fl_d = i.s1 & 8'hCF; sp_d = sp_q + 8'd1; end
      OP_RTI: begin
        fl_d = i.s1 & 8'hCF; pc_n = {i.s3, i.s2}; sp_d = sp_q + 8'd3;
      end
      OP_RTS: begin pc_n = {i.s2, i.s1} + 16'd1; sp_d = sp_q + 8'd2; end
      OP_STA: begin wv = 1'b1; wa = i.addr; wd = a_q; end
      OP_STX: begin wv = 1'b1; wa = i.addr; wd = x_q; end
      OP_STY: begin wv = 1'b1; wa = i.addr; wd = y_q; end
      OP_TAX: begin x_d = a_q; r = a_q; end
      OP_TAY: begin y_d = a_q; r = a_q; end
      OP_TSX: begin x_d = sp_q; r = sp_q; end
      OP_TXA: begin a_d = x_q; r = x_q; end
      OP_TXS: sp_d = x_q;
      OP_TYA: begin a_d = y_q; r = y_q; end
      default: ;
    endcase
    // N and Z follow r for every kind that computes a value
    case (i.op)
      OP_ADC, OP_SBC, OP_AND, OP_EOR, OP_ORA, OP_ASL, OP_LSR, OP_ROL, OP_ROR,
      OP_CMP, OP_CPX, OP_CPY, OP_DEC, OP_INC, OP_DEX, OP_DEY, OP_INX, OP_INY,
      OP_LDA, OP_LDX, OP_LDY, OP_PLA, OP_TAX, OP_TAY, OP_TSX, OP_TXA,
      OP_TYA: begin
        fl_d[7] = r[7]; fl_d[1] = (r == 8'd0);
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; sp_q <= 8'd0; fl_q <= 8'd0;
      ov_q <= 1'b0; jsr2_q <= 1'b0;
    end else begin
      if (take) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; fl_q <= fl_d;
        ov_q <= 1'b1;
        jsr2_q <= (i.op == OP_JSR);
      end else if (fire) begin
        ov_q <= 1'b1; jsr2_q <= 1'b0;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= '{wv: wv, wa: wa, wd: wd, last: (i.op != OP_JSR), a: a_d, x: x_d,
                 y: y_d, sp: sp_d, fl: fl_d & 8'hDF, pc: pc_n};
      ret_lo_q <= ret[7:0];
      jsr_wa_q <= STACK_BASE + {8'd0, sp_q - 8'd1};
    end else if (fire) begin
      res_q.wa   <= jsr_wa_q;
      res_q.wd   <= ret_lo_q;
      res_q.last <= 1'b1;
    end
  end

endmodule

/* rtl/core/eight_bit_cpu_execute_unit.sv */
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit
// Execute unit of an 8-bit accumulator processor, binary arithmetic only.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)
// s_axis  | in  | operation[5:0] operand_address[21:6] mem_data[29:22]
//         |     | pc_in[45:30] stack_byte_one..three[69:46], pad to 72
// m_axis  | out | write_valid, write_address, write_data, acc, x, y, sp,
//         |     | flags, pc (packed to 81, pad to 88); tlast = last_result
// One instruction per cycle unless the output stalls; JSR gives two write beats.
// The register file update in the back end sets this rate.
// Reset clears registers and queue. A two-entry queue parts front and
// back; an output register holds a stalled result beat.
module eight_bit_cpu_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // operation, operand_address, mem_data, pc_in,
                                        // stack_byte_one, two, three
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // write_valid, write_address, write_data,
                                        // acc_out, x_out, y_out, sp_out, flags_out, pc_out
  output logic        m_axis_tlast_o
);
  import ebcx_pkg::*;

  logic    q_valid, q_ready;
  instr_t  q_data;
  result_t res;

  ebcx_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .op_i       (s_axis_tdata_i[5:0]),
    .addr_i     (s_axis_tdata_i[21:6]),
    .mem_i      (s_axis_tdata_i[29:22]),
    .pc_i       (s_axis_tdata_i[45:30]),
    .s1_i       (s_axis_tdata_i[53:46]),
    .s2_i       (s_axis_tdata_i[61:54]),
    .s3_i       (s_axis_tdata_i[69:62]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  ebcx_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  assign m_axis_tlast_o = res.last;
  assign m_axis_tdata_o = {7'd0, res.pc, res.fl, res.sp, res.y, res.x, res.a,
                           res.wd, res.wa, res.wv};

endmodule

/* rtl/core/ebcx_checker.sv */
// ----------------------------------------------------------------------------
// ebcx_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module ebcx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [87:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);
  // no write means zero address and data
  a_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[24:1] == 24'd0)
    else $error("write fields set without write");
  // flag bit 5 stays clear
  a_flag5: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[62])
    else $error("flag bit 5 set");
  // first beat of a call always writes
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[0])
    else $error("non-last beat without write");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");
endmodule

bind eight_bit_cpu_execute_unit ebcx_checker u_ebcx_checker (.*);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the 8-bit processor execute unit. Decoded
// instructions are driven into the slave port and every result beat is
// compared against a cycle-free model of the register file and flags.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ebcx_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam logic [7:0] FL_C = 8'h01, FL_Z = 8'h02, FL_I = 8'h04, FL_D = 8'h08;
  localparam logic [7:0] FL_V = 8'h40, FL_N = 8'h80;
  localparam logic [7:0] FL_KEEP = 8'hDF, FL_PULL = 8'hCF;

  typedef struct packed {
    logic [7:0]  s3;
    logic [7:0]  s2;
    logic [7:0]  s1;
    logic [15:0] pc;
    logic [7:0]  mem;
    logic [15:0] addr;
    logic [5:0]  op;
  } instr_beat_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  fl;
    logic [7:0]  sp;
    logic [7:0]  y;
    logic [7:0]  x;
    logic [7:0]  a;
    logic [7:0]  wd;
    logic [15:0] wa;
    logic        wv;
  } exec_beat_t;

  typedef struct packed {
    exec_beat_t  data;
    logic        last;
  } exec_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [87:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  eight_bit_cpu_execute_unit u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [7:0] acc_q, x_q, y_q, sp_q, fl_q;

  instr_beat_t instr_q[$];
  exec_exp_t   exec_q[$];
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned errors = 0, beats_in = 0, beats_out = 0, idle_cycles = 0;
  bit          hold_send = 1'b0;
  bit          in_fire = 1'b0;

  function automatic void set_nz(logic [7:0] v);
    fl_q = (fl_q & ~(FL_N | FL_Z)) | (v & FL_N) | ((v == 8'h00) ? FL_Z : 8'h00);
  endfunction

  function automatic void set_fl(logic [7:0] bitm, bit on);
    fl_q = on ? (fl_q | bitm) : (fl_q & ~bitm);
  endfunction

  function automatic void add_with_carry(logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, acc_q} + {1'b0, m} + {8'h00, fl_q[0]};
    set_fl(FL_C, sum[8]);
    set_fl(FL_V, (~(acc_q[7] ^ m[7])) & (acc_q[7] ^ sum[7]));
    acc_q = sum[7:0];
    set_nz(acc_q);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
    set_fl(FL_C, r >= m);
    set_nz(r - m);
  endfunction

  function automatic exec_exp_t make_beat(bit wv, logic [15:0] wa, logic [7:0] wd,
                                          bit last, logic [15:0] pc);
    exec_exp_t e;
    e.data.wv = wv;
    e.data.wa = wv ? wa : 16'h0;
    e.data.wd = wv ? wd : 8'h0;
    e.data.a = acc_q;
    e.data.x = x_q;
    e.data.y = y_q;
    e.data.sp = sp_q;
    e.data.fl = fl_q & FL_KEEP;
    e.data.pc = pc;
    e.last = last;
    return e;
  endfunction

  // executes one instruction and queues its expected result beats
  function automatic void execute_instr(instr_beat_t it);
    bit          wv, acc_mode;
    logic [15:0] wa, pc, ret;
    logic [7:0]  wd, cur, r;
    wv = 0; wa = '0; wd = '0; pc = it.pc;
    acc_mode = (it.addr == 16'h0);
    cur = acc_mode ? acc_q : it.mem;
    case (it.op)
      OP_ADC: add_with_carry(it.mem);
      OP_SBC: add_with_carry(~it.mem);
      OP_AND: begin acc_q &= it.mem; set_nz(acc_q); end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        case (it.op)
          OP_ASL: r = {cur[6:0], 1'b0};
          OP_LSR: r = {1'b0, cur[7:1]};
          OP_ROL: r = {cur[6:0], fl_q[0]};
          default: r = {fl_q[0], cur[7:1]};
        endcase
        set_fl(FL_C, (it.op == OP_ASL || it.op == OP_ROL) ? cur[7] : cur[0]);
        set_nz(r);
        if (acc_mode) acc_q = r;
        else begin wv = 1; wa = it.addr; wd = r; end
      end
      OP_BCC: if (!fl_q[0]) pc = it.addr;
      OP_BCS: if (fl_q[0]) pc = it.addr;
      OP_BEQ: if (fl_q[1]) pc = it.addr;
      OP_BMI: if (fl_q[7]) pc = it.addr;
      OP_BNE: if (!fl_q[1]) pc = it.addr;
      OP_BPL: if (!fl_q[7]) pc = it.addr;
      OP_BVC: if (!fl_q[6]) pc = it.addr;
      OP_BVS: if (fl_q[6]) pc = it.addr;
      OP_BIT: begin
        set_fl(FL_N, it.mem[7]);
        set_fl(FL_V, it.mem[6]);
        set_fl(FL_Z, (acc_q & it.mem) == 8'h0);
      end
      OP_CLC: set_fl(FL_C, 0);
      OP_CLD: set_fl(FL_D, 0);
      OP_CLI: set_fl(FL_I, 0);
      OP_CLV: set_fl(FL_V, 0);
      OP_CMP: compare_reg(acc_q, it.mem);
      OP_CPX: compare_reg(x_q, it.mem);
      OP_CPY: compare_reg(y_q, it.mem);
      OP_DEC, OP_INC: begin
        r = (it.op == OP_DEC) ? it.mem - 8'd1 : it.mem + 8'd1;
        set_nz(r);
        wv = 1; wa = it.addr; wd = r;
      end
      OP_DEX: begin x_q--; set_nz(x_q); end
      OP_DEY: begin y_q--; set_nz(y_q); end
      OP_EOR: begin acc_q ^= it.mem; set_nz(acc_q); end
      OP_INX: begin x_q++; set_nz(x_q); end
      OP_INY: begin y_q++; set_nz(y_q); end
      OP_JMP: pc = it.addr;
      OP_JSR: begin
        ret = it.pc - 16'd1;
        wa = STACK_BASE + {8'h0, sp_q};
        r = sp_q - 8'd1;
        sp_q = sp_q - 8'd2;
        exec_q.push_back(make_beat(1, wa, ret[15:8], 0, it.addr));
        exec_q.push_back(make_beat(1, STACK_BASE + {8'h0, r}, ret[7:0], 1, it.addr));
        return;
      end
      OP_LDA: begin acc_q = it.mem; set_nz(it.mem); end
      OP_LDX: begin x_q = it.mem; set_nz(it.mem); end
      OP_LDY: begin y_q = it.mem; set_nz(it.mem); end
      OP_ORA: begin acc_q |= it.mem; set_nz(acc_q); end
      OP_PHA, OP_PHP: begin
        wv = 1; wa = STACK_BASE + {8'h0, sp_q};
        wd = (it.op == OP_PHA) ? acc_q : (fl_q & FL_KEEP);
        sp_q--;
      end
      OP_PLA: begin acc_q = it.s1; sp_q++; set_nz(it.s1); end
      OP_PLP: begin fl_q = it.s1 & FL_PULL; sp_q++; end
      OP_RTI: begin
        fl_q = it.s1 & FL_PULL;
        pc = {it.s3, it.s2};
        sp_q = sp_q + 8'd3;
      end
      OP_RTS: begin pc = {it.s2, it.s1} + 16'd1; sp_q = sp_q + 8'd2; end
      OP_SEC: set_fl(FL_C, 1);
      OP_SED: set_fl(FL_D, 1);
      OP_SEI: set_fl(FL_I, 1);
      OP_STA: begin wv = 1; wa = it.addr; wd = acc_q; end
      OP_STX: begin wv = 1; wa = it.addr; wd = x_q; end
      OP_STY: begin wv = 1; wa = it.addr; wd = y_q; end
      OP_TAX: begin x_q = acc_q; set_nz(x_q); end
      OP_TAY: begin y_q = acc_q; set_nz(y_q); end
      OP_TSX: begin x_q = sp_q; set_nz(x_q); end
      OP_TXA: begin acc_q = x_q; set_nz(acc_q); end
      OP_TXS: sp_q = x_q;
      OP_TYA: begin acc_q = y_q; set_nz(acc_q); end
      default: ;
    endcase
    exec_q.push_back(make_beat(wv, wa, wd, 1, pc));
  endfunction

  // driver: a new beat only once the current one was taken at the last edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_fire) begin
        if (instr_q.size() != 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {2'b00, instr_q[0]};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: input acceptance drives the model, output beats are checked
  always @(posedge clk_i) begin
    exec_exp_t  e;
    exec_beat_t got;
    bit         hit;
    if (rst_ni) begin
      hit = 1'b0;
      in_fire <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        execute_instr(instr_q.pop_front());
        beats_in++;
        hit = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        hit = 1'b1;
        beats_out++;
        got = m_axis_tdata_o[80:0];
        if (exec_q.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata_o);
          errors++;
        end else begin
          e = exec_q.pop_front();
          if (got.wv !== e.data.wv) begin
            $error("write_valid exp %0h got %0h", e.data.wv, got.wv); errors++; end
          if (got.wa !== e.data.wa) begin
            $error("write_address exp %h got %h", e.data.wa, got.wa); errors++; end
          if (got.wd !== e.data.wd) begin
            $error("write_data exp %h got %h", e.data.wd, got.wd); errors++; end
          if (m_axis_tlast_o !== e.last) begin
            $error("last_result exp %0h got %0h", e.last, m_axis_tlast_o); errors++; end
          if (got.a !== e.data.a) begin
            $error("acc_out exp %h got %h", e.data.a, got.a); errors++; end
          if (got.x !== e.data.x) begin
            $error("x_out exp %h got %h", e.data.x, got.x); errors++; end
          if (got.y !== e.data.y) begin
            $error("y_out exp %h got %h", e.data.y, got.y); errors++; end
          if (got.sp !== e.data.sp) begin
            $error("sp_out exp %h got %h", e.data.sp, got.sp); errors++; end
          if (got.fl !== e.data.fl) begin
            $error("flags_out exp %h got %h", e.data.fl, got.fl); errors++; end
          if (got.pc !== e.data.pc) begin
            $error("pc_out exp %h got %h", e.data.pc, got.pc); errors++; end
        end
      end
      idle_cycles <= hit ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic instr_beat_t rand_instr(logic [5:0] op);
    instr_beat_t it;
    it.op   = op;
    it.addr = ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom);
    it.mem  = 8'($urandom);
    it.pc   = 16'($urandom);
    it.s1   = 8'($urandom);
    it.s2   = 8'($urandom);
    it.s3   = 8'($urandom);
    return it;
  endfunction

  task automatic drain();
    while (instr_q.size() != 0 || exec_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
  endtask

  initial begin
    instr_beat_t it;
    int unsigned ph, k;
    acc_q = 0; x_q = 0; y_q = 0; sp_q = 0; fl_q = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: every kind once, field extremes, accumulator vs memory shifts
    for (int op = 0; op <= 54; op++) begin
      it = rand_instr(6'(op));
      if (op % 2 == 0) begin
        it.addr = 16'h0; it.mem = 8'h00; it.pc = 16'h0;
        it.s1 = 8'h00; it.s2 = 8'h00; it.s3 = 8'h00;
      end else begin
        it.addr = 16'hFFFF; it.mem = 8'hFF; it.pc = 16'hFFFF;
        it.s1 = 8'hFF; it.s2 = 8'hFF; it.s3 = 8'hFF;
      end
      instr_q.push_back(it);
    end
    // an unknown kind, plus PHP after a PLP of all ones, which masks B out
    it = rand_instr(6'd63); instr_q.push_back(it);
    it = rand_instr(OP_PLP); it.s1 = 8'hFF; instr_q.push_back(it);
    it = rand_instr(OP_PHP); instr_q.push_back(it);
    drain();

    // random phases with different idle/stall mixes
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 46) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 46) : 0;
      if (ph == 0) send_idle_pct = 0;
      for (k = 0; k < 220; k++) begin
        // mostly real kinds, a few past the end of the table
        instr_q.push_back(rand_instr(($urandom_range(19) == 0) ?
                                     6'($urandom_range(63, 55)) : 6'($urandom_range(54))));
        if (k == 110) begin
          // hold the sender until every result has come back
          while (instr_q.size() != 0) @(posedge clk_i);
          hold_send = 1'b1;
          while (exec_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
          repeat (4) @(posedge clk_i);
          hold_send = 1'b0;
        end
      end
      drain();
    end
    repeat (20) @(posedge clk_i);
    $display("Ran %0d instructions over four idle/stall mixes, %0d result beats checked.",
             beats_in, beats_out);
    if (errors == 0 && exec_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ebcx_pkg.sv
rtl/core/ebcx_front.sv
rtl/core/ebcx_back.sv
rtl/core/eight_bit_cpu_execute_unit.sv
rtl/core/ebcx_checker.sv
dv/testbench.sv
